[hw/rtl/cwbr_pkg.sv]
// Shared types, constants and saturation helpers for the convolution window
// with batch-norm and ReLU. No dependencies.
package cwbr_pkg;

  // Q8.24 limits and the batch-norm epsilon code
  localparam logic signed [31:0] QMax    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin    = 32'sh8000_0000;
  localparam logic [31:0]        EpsCode = 32'd1678;

  // Iteration counts and operand widths of the shared divide / root unit
  localparam int unsigned DivSteps  = 56;
  localparam int unsigned SqrtSteps = 28;
  localparam int unsigned NumW      = 56;
  localparam int unsigned ResW      = 57;

  typedef enum logic [1:0] {
    ITER_SQRT = 2'b01,
    ITER_DIV  = 2'b10
  } iter_op_e;

  // Control from sequencer to the iterative unit
  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_ctl_t;

  // Status back from the iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

  typedef struct packed {
    logic              flag;
    logic signed [31:0] val;
  } sat_t;

  // Signed value from sign and magnitude, saturated to Q8.24
  function automatic sat_t sat_mag(logic neg, logic [63:0] mag);
    sat_t r;
    r.flag = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.flag = 1'b1;
        r.val  = QMin;
      end else begin
        r.val = ~mag[31:0] + 32'd1;
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        r.flag = 1'b1;
        r.val  = QMax;
      end else begin
        r.val = mag[31:0];
      end
    end
    return r;
  endfunction

  // Round a Q16.48 product to Q8.24, ties away from zero
  function automatic sat_t round_sat(logic signed [63:0] p);
    logic [63:0] mag;
    mag = p[63] ? (~p + 64'd1) : p;
    mag = (mag + 64'h80_0000) >> 24;
    return sat_mag(p[63], mag);
  endfunction

  // Clamp a 33-bit sum to Q8.24
  function automatic sat_t sat_sum(logic signed [32:0] s);
    sat_t r;
    r.flag = s[32] != s[31];
    if (r.flag) begin
      r.val = s[32] ? QMin : QMax;
    end else begin
      r.val = s[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/cwbr_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing.
interface cwbr_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [5:0]         filt_idx;
  logic signed [31:0] activation;
  logic signed [31:0] weight;
  logic signed [31:0] norm_mean;
  logic [30:0]        norm_variance;
  logic signed [31:0] norm_gamma;
  logic signed [31:0] norm_beta;
  logic               last;

  modport source (output valid, mode, filt_idx, activation, weight, norm_mean,
                  norm_variance, norm_gamma, norm_beta, last, input ready);
  modport sink (input valid, mode, filt_idx, activation, weight, norm_mean,
                norm_variance, norm_gamma, norm_beta, last, output ready);
endinterface

interface cwbr_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  out_filter;
  logic [30:0] activation_out;
  logic        overflow;

  modport source (output valid, out_filter, activation_out, overflow, input ready);
  modport sink (input valid, out_filter, activation_out, overflow, output ready);
endinterface

[hw/rtl/conv_window_bn_relu_unit.sv]
// Convolution window accumulate with batch-norm and ReLU, signed Q8.24.
// Accumulate beat: multiply, then round and add, before the next accept.
// Last beat: result valid after subtract, 56-step divide, multiply, round, output;
// no divide when the root is zero; a stalled result holds off the next beat.
// Load beat: the 28-step square root runs before the table write.
// Reset (async, low) clears sum, flag and control; the table holds undefined data.
module conv_window_bn_relu_unit #(
  parameter int unsigned NUM_FILTERS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cwbr_in_if.sink    in_i,
  cwbr_out_if.source out_o
);

  localparam int unsigned AddrW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_SQRT = 10'b00_0000_0010,
    ST_MUL  = 10'b00_0000_0100,
    ST_ACC  = 10'b00_0000_1000,
    ST_SUB  = 10'b00_0001_0000,
    ST_DVS  = 10'b00_0010_0000,
    ST_DIV  = 10'b00_0100_0000,
    ST_MULG = 10'b00_1000_0000,
    ST_RND  = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic signed [31:0] mean;
    logic signed [31:0] root;
    logic signed [31:0] gamma;
    logic signed [31:0] beta;
  } entry_t;

  state_e state_q, state_d;

  logic               last_q, sum_ovf_q, flag_q, oor_q, dneg_q;
  logic [5:0]         idx_q;
  logic signed [31:0] a_q, w_q, sum_q, diff_q, q_q;
  logic signed [31:0] ld_mean_q, ld_gamma_q, ld_beta_q;
  logic signed [63:0] prod_q;

  logic               out_valid_q, out_ovf_q;
  logic [5:0]         out_filter_q;
  logic [30:0]        out_act_q;

  entry_t mem_q [NUM_FILTERS];
  entry_t rdata_q, ent;
  logic   mem_we;

  cwbr_pkg::iter_ctl_t iter_ctl;
  cwbr_pkg::iter_sts_t iter_sts;
  logic [cwbr_pkg::NumW-1:0] iter_num;
  logic [31:0]               iter_den;
  logic [cwbr_pkg::ResW-1:0] iter_res;

  logic              accept, out_free;
  logic [31:0]       in_idx_ext, q_idx_ext;
  logic [AddrW-1:0]  raddr, waddr;
  logic [31:0]       var_eps, var_sat;
  logic [31:0]       mn, md;

  cwbr_pkg::sat_t prod_rs, acc_rs, sub_rs, quo_rs, beta_rs;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  assign in_idx_ext = 32'(in_i.filt_idx);
  assign q_idx_ext  = 32'(idx_q);
  assign raddr      = in_idx_ext[AddrW-1:0];
  assign waddr      = q_idx_ext[AddrW-1:0];
  assign ent        = oor_q ? '0 : rdata_q;

  // Variance plus epsilon, clamped, as the root operand
  assign var_eps = {1'b0, in_i.norm_variance} + cwbr_pkg::EpsCode;
  assign var_sat = var_eps[31] ? 32'h7FFF_FFFF : var_eps;

  // Divider operand magnitudes
  assign mn = diff_q[31] ? (~diff_q + 32'd1) : diff_q;
  assign md = ent.root[31] ? (~ent.root + 32'd1) : ent.root;

  // Arithmetic steps
  assign prod_rs = cwbr_pkg::round_sat(prod_q);
  assign acc_rs  = cwbr_pkg::sat_sum(33'(sum_q) + 33'(prod_rs.val));
  assign sub_rs  = cwbr_pkg::sat_sum(33'(sum_q) - 33'(ent.mean));
  assign quo_rs  = cwbr_pkg::sat_mag(dneg_q, 64'(iter_res));
  assign beta_rs = cwbr_pkg::sat_sum(33'(q_q) + 33'(ent.beta));

  // Iterative unit start
  always_comb begin
    iter_ctl.start = 1'b0;
    iter_ctl.op    = cwbr_pkg::ITER_SQRT;
    iter_num       = {1'b0, var_sat[30:0], 24'd0};
    iter_den       = md;
    if (accept && !in_i.mode) begin
      iter_ctl.start = 1'b1;
    end else if (state_q == ST_DVS && md != 32'd0) begin
      iter_ctl.start = 1'b1;
      iter_ctl.op    = cwbr_pkg::ITER_DIV;
      iter_num       = {mn, 24'd0};
    end
  end

  cwbr_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (iter_ctl),
    .num_i  (iter_num),
    .den_i  (iter_den),
    .sts_o  (iter_sts),
    .res_o  (iter_res)
  );

  assign mem_we = (state_q == ST_SQRT) && iter_sts.done && (q_idx_ext < NUM_FILTERS);

  // Parameter table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= '{mean: ld_mean_q, root: 32'(iter_res), gamma: ld_gamma_q,
                        beta: ld_beta_q};
    end
    if (accept) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = in_i.mode ? ST_MUL : ST_SQRT;
      ST_SQRT: if (iter_sts.done) state_d = ST_IDLE;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = last_q ? ST_SUB : ST_IDLE;
      ST_SUB:  state_d = ST_DVS;
      ST_DVS:  state_d = (md == 32'd0) ? ST_MULG : ST_DIV;
      ST_DIV:  if (iter_sts.done) state_d = ST_MULG;
      ST_MULG: state_d = ST_RND;
      ST_RND:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      sum_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC) begin
        sum_q     <= acc_rs.val;
        sum_ovf_q <= sum_ovf_q | prod_rs.flag | acc_rs.flag;
      end else if (state_q == ST_SUB) begin
        sum_q     <= '0;
        sum_ovf_q <= 1'b0;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q      <= in_i.filt_idx;
      last_q     <= in_i.last;
      a_q        <= in_i.activation;
      w_q        <= in_i.weight;
      ld_mean_q  <= in_i.norm_mean;
      ld_gamma_q <= in_i.norm_gamma;
      ld_beta_q  <= in_i.norm_beta;
      oor_q      <= !(in_idx_ext < NUM_FILTERS);
    end
    case (state_q)
      ST_MUL:  prod_q <= a_q * w_q;
      ST_SUB: begin
        diff_q <= sub_rs.val;
        flag_q <= sum_ovf_q | sub_rs.flag;
      end
      ST_DVS: begin
        dneg_q <= diff_q[31] ^ ent.root[31];
        if (md == 32'd0) begin
          q_q    <= (mn == 32'd0) ? 32'sd0 : (diff_q[31] ? cwbr_pkg::QMin : cwbr_pkg::QMax);
          flag_q <= flag_q | (mn != 32'd0);
        end
      end
      ST_DIV: if (iter_sts.done) begin
        q_q    <= quo_rs.val;
        flag_q <= flag_q | quo_rs.flag;
      end
      ST_MULG: prod_q <= ent.gamma * q_q;
      ST_RND: begin
        q_q    <= prod_rs.val;
        flag_q <= flag_q | prod_rs.flag;
      end
      ST_OUT: if (out_free) begin
        out_filter_q <= idx_q;
        out_act_q    <= beta_rs.val[31] ? 31'd0 : beta_rs.val[30:0];
        out_ovf_q    <= flag_q | beta_rs.flag;
      end
      default: ;
    endcase
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_filter     = out_filter_q;
  assign out_o.activation_out = out_act_q;
  assign out_o.overflow       = out_ovf_q;

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_sts.done |-> (state_q == ST_SQRT || state_q == ST_DIV))
    else $error("iterative unit finished outside a wait state");
  a_we_in_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_SQRT))
    else $error("table write outside load");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result beat without normalization");
  a_acc_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.mode) |=> (state_q == ST_MUL))
    else $error("accumulate beat did not start multiply");
`endif

endmodule

[hw/rtl/cwbr_iter.sv]
// Bit-serial unit: restoring divide (56 steps) or digit-by-digit square root
// (28 steps), both rounded to nearest. Depends on cwbr_pkg.
module cwbr_iter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cwbr_pkg::iter_ctl_t          ctl_i,
  input  logic [cwbr_pkg::NumW-1:0]    num_i,
  input  logic [31:0]                  den_i,
  output cwbr_pkg::iter_sts_t          sts_o,
  output logic [cwbr_pkg::ResW-1:0]    res_o
);

  logic              busy_q, done_q;
  cwbr_pkg::iter_op_e op_q;
  logic [5:0]        cnt_q;
  logic [55:0]       acc_q;   // div: dividend/quotient; sqrt: remainder x
  logic [54:0]       rem_q;   // div: partial remainder; sqrt: root r
  logic [54:0]       bit_q;
  logic [31:0]       den_q;

  logic [32:0] trial;
  logic [54:0] t_sum;
  assign trial = {rem_q[31:0], acc_q[55]};
  assign t_sum = rem_q + bit_q;

  // Step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= cwbr_pkg::ITER_SQRT;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start && !busy_q) begin
        busy_q <= 1'b1;
        op_q   <= ctl_i.op;
        cnt_q  <= (ctl_i.op == cwbr_pkg::ITER_DIV) ? 6'(cwbr_pkg::DivSteps)
                                                    : 6'(cwbr_pkg::SqrtSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (ctl_i.start && !busy_q) begin
      acc_q <= num_i;
      rem_q <= '0;
      bit_q <= 55'(1) << 54;
      den_q <= den_i;
    end else if (busy_q) begin
      case (op_q)
        cwbr_pkg::ITER_DIV: begin
          if (trial >= {1'b0, den_q}) begin
            rem_q <= 55'(trial - {1'b0, den_q});
            acc_q <= {acc_q[54:0], 1'b1};
          end else begin
            rem_q <= 55'(trial);
            acc_q <= {acc_q[54:0], 1'b0};
          end
        end
        default: begin
          if (acc_q[54:0] >= t_sum) begin
            acc_q <= {1'b0, acc_q[54:0] - t_sum};
            rem_q <= (rem_q >> 1) + bit_q;
          end else begin
            rem_q <= rem_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      endcase
    end
  end

  // Final rounding
  always_comb begin
    if (op_q == cwbr_pkg::ITER_DIV) begin
      res_o = {1'b0, acc_q} + (({rem_q[31:0], 1'b0} >= {1'b0, den_q}) ? 57'd1 : 57'd0);
    end else begin
      res_o = {2'b0, rem_q} + ((acc_q[54:0] > rem_q) ? 57'd1 : 57'd0);
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

[verif/conv_window_bn_relu_unit_test.sv]
// Self-checking testbench for conv_window_bn_relu_unit: drives load and accumulate
// beats, predicts results with a Q8.24 batch-norm model. Depends on cwbr_pkg, cwbr_if.
module conv_window_bn_relu_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic               mode;
    logic [5:0]         filt_idx;
    logic signed [31:0] activation;
    logic signed [31:0] weight;
    logic signed [31:0] norm_mean;
    logic [30:0]        norm_variance;
    logic signed [31:0] norm_gamma;
    logic signed [31:0] norm_beta;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic [5:0]  filter;
    logic [30:0] act;
    logic        ovf;
  } bn_result_t;

  logic clk_i;
  logic rst_ni;

  cwbr_in_if  in_ch ();
  cwbr_out_if out_ch ();

  conv_window_bn_relu_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Predictor state
  logic signed [31:0] acc_sum;
  logic               acc_ovf;
  logic signed [31:0] bn_mean  [64];
  logic signed [31:0] bn_root  [64];
  logic signed [31:0] bn_gamma [64];
  logic signed [31:0] bn_beta  [64];
  bit                 loaded   [64];

  bn_result_t expected_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned beats_sent;
  int unsigned idle_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Saturate a 64-bit value to Q8.24
  function automatic logic signed [31:0] clamp_q(input logic signed [63:0] v,
                                                 inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Signed magnitude to Q8.24 with saturation
  function automatic logic signed [31:0] from_mag(input logic neg, input logic [63:0] mag,
                                                  inout logic flag);
    logic signed [63:0] s;
    if (neg) begin
      s = -$signed({1'b0, mag[62:0]});
      if (mag > 64'h8000_0000) s = -64'sd4294967296;
    end else begin
      s = $signed({1'b0, mag[62:0]});
      if (mag > 64'h7FFF_FFFF) s = 64'sd4294967296;
    end
    return clamp_q(s, flag);
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                inout logic flag);
    logic signed [63:0] p;
    logic [63:0]        mag;
    p   = 64'(a) * 64'(b);
    mag = p[63] ? 64'(-p) : 64'(p);
    mag = (mag + 64'h80_0000) >> 24;
    return from_mag(p[63], mag, flag);
  endfunction

  function automatic logic signed [31:0] fx_div(input logic signed [31:0] n,
                                                input logic signed [31:0] d,
                                                inout logic flag);
    logic        neg;
    logic [63:0] mn, md;
    neg = n[31] != d[31];
    mn  = n[31] ? 64'(-64'(n)) : 64'(n);
    md  = d[31] ? 64'(-64'(d)) : 64'(d);
    if (md == 0) begin
      if (mn == 0) return 32'sd0;
      flag = 1'b1;
      return n[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    mn = mn << 24;
    return from_mag(neg, (2 * mn + md) / (2 * md), flag);
  endfunction

  // Rounded integer square root
  function automatic logic [63:0] root_round(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (x > r) r = r + 1;
    return r;
  endfunction

  // Apply one accepted beat to the predictor
  task automatic predict_beat(input beat_t b);
    logic               f;
    logic [63:0]        v;
    logic signed [31:0] x;
    bn_result_t         r;
    if (b.mode == 1'b0) begin
      v = 64'(b.norm_variance) + 64'(cwbr_pkg::EpsCode);
      if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
      bn_mean[b.filt_idx]  = b.norm_mean;
      bn_root[b.filt_idx]  = 32'(root_round(v << 24));
      bn_gamma[b.filt_idx] = b.norm_gamma;
      bn_beta[b.filt_idx]  = b.norm_beta;
      return;
    end
    f       = acc_ovf;
    x       = fx_mul(b.activation, b.weight, f);
    acc_sum = clamp_q(64'(acc_sum) + 64'(x), f);
    acc_ovf = f;
    if (!b.last) return;
    x = clamp_q(64'(acc_sum) - 64'(bn_mean[b.filt_idx]), f);
    x = fx_div(x, bn_root[b.filt_idx], f);
    x = fx_mul(bn_gamma[b.filt_idx], x, f);
    x = clamp_q(64'(x) + 64'(bn_beta[b.filt_idx]), f);
    if (x < 0) x = '0;
    r.filter = b.filt_idx;
    r.act    = x[30:0];
    r.ovf    = f;
    expected_q.push_back(r);
    acc_sum = '0;
    acc_ovf = 1'b0;
  endtask

  // Send one beat after a random gap; predict on acceptance.
  // Valid stays high after the beat; the next call or the caller drops it.
  task automatic send_beat(input beat_t b);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= b.mode;
    in_ch.filt_idx      <= b.filt_idx;
    in_ch.activation    <= b.activation;
    in_ch.weight        <= b.weight;
    in_ch.norm_mean     <= b.norm_mean;
    in_ch.norm_variance <= b.norm_variance;
    in_ch.norm_gamma    <= b.norm_gamma;
    in_ch.norm_beta     <= b.norm_beta;
    in_ch.last          <= b.last;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_beat(b);
    if (b.mode == 1'b0) loaded[b.filt_idx] = 1'b1;
    beats_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      3: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic beat_t load_beat(input logic [5:0] idx);
    beat_t b;
    b               = '0;
    b.filt_idx      = idx;
    b.norm_mean     = rand_q();
    b.norm_variance = $urandom_range(0, 3) == 0 ? 31'($urandom)
                                                : 31'($urandom_range(0, 32'h0400_0000));
    b.norm_gamma    = rand_q();
    b.norm_beta     = rand_q();
    b.last          = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic beat_t acc_beat(input logic [5:0] idx, input logic last);
    beat_t b;
    b.mode          = 1'b1;
    b.filt_idx      = last ? idx : 6'($urandom);
    b.activation    = rand_q();
    b.weight        = rand_q();
    b.norm_mean     = $urandom;
    b.norm_variance = 31'($urandom);
    b.norm_gamma    = $urandom;
    b.norm_beta     = $urandom;
    b.last          = last;
    return b;
  endfunction

  function automatic logic [5:0] pick_loaded();
    logic [5:0] i;
    do i = 6'($urandom); while (!loaded[i]);
    return i;
  endfunction

  // Result checker and receiver stalls
  initial begin
    bn_result_t exp_r;
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: filter %0d act %h ovf %b", out_ch.out_filter,
                   out_ch.activation_out, out_ch.overflow);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_ch.out_filter !== exp_r.filter || out_ch.activation_out !== exp_r.act ||
            out_ch.overflow !== exp_r.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp filter %0d act %h ovf %b, got filter %0d act %h ovf %b",
                     exp_r.filter, exp_r.act, exp_r.ovf, out_ch.out_filter,
                     out_ch.activation_out, out_ch.overflow);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake on the input or output channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[conv_window_bn_relu_unit] ERROR");
        $finish;
      end
    end
  end

  // Directed: field extremes on a few filters, both modes, saturation, ReLU
  task automatic test_directed();
    beat_t b;
    b = '0;
    b.filt_idx = 6'd0;  b.norm_variance = 31'h7FFF_FFFF;
    b.norm_mean = 32'h8000_0000; b.norm_gamma = 32'h7FFF_FFFF; b.norm_beta = 32'h7FFF_FFFF;
    b.last = 1'b1;
    send_beat(b);
    b = '0;
    b.filt_idx = 6'd63; b.norm_variance = 31'd0; b.norm_mean = 32'h7FFF_FFFF;
    b.norm_gamma = 32'h8000_0000; b.norm_beta = 32'h8000_0000;
    send_beat(b);
    b = '0;
    b.filt_idx = 6'd1; b.norm_gamma = 32'h0100_0000; b.norm_variance = 31'h0100_0000;
    send_beat(b);
    // sum saturates positive then continues
    b = acc_beat(6'd0, 1'b0); b.activation = 32'h7FFF_FFFF; b.weight = 32'h7FFF_FFFF;
    send_beat(b); send_beat(b);
    b.last = 1'b1; b.filt_idx = 6'd0; send_beat(b);
    // negative saturation, filter 63
    b = acc_beat(6'd63, 1'b0); b.activation = 32'h8000_0000; b.weight = 32'h7FFF_FFFF;
    send_beat(b);
    b.activation = 32'h8000_0000; b.weight = 32'h8000_0000; b.last = 1'b1;
    b.filt_idx = 6'd63; send_beat(b);
    // single-beat windows with zero and small values, ReLU on negative
    b = acc_beat(6'd1, 1'b1); b.activation = '0; b.weight = '0; send_beat(b);
    b = acc_beat(6'd1, 1'b1); b.activation = -32'sh0100_0000; b.weight = 32'h0100_0000;
    send_beat(b);
    b = acc_beat(6'd1, 1'b1); b.activation = 32'h0000_0001; b.weight = 32'h0080_0000;
    send_beat(b);
    b = acc_beat(6'd1, 1'b1); b.activation = 32'hFFFF_FFFF; b.weight = 32'h0080_0000;
    send_beat(b);
  endtask

  // Random: occasional reloads, mostly windows on loaded filters
  task automatic test_random(input int unsigned n_beats);
    int unsigned sent, len;
    logic [5:0]  idx;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(0, 5) == 0) begin
        send_beat(load_beat(6'($urandom)));
        sent++;
      end else begin
        idx = pick_loaded();
        len = $urandom_range(0, 7) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 6);
        for (int unsigned k = 1; k < len; k++) send_beat(acc_beat(idx, 1'b0));
        send_beat(acc_beat(idx, 1'b1));
        sent += len;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0; in_ch.mode = 1'b0; in_ch.filt_idx = '0;
    in_ch.activation = '0; in_ch.weight = '0; in_ch.norm_mean = '0;
    in_ch.norm_variance = '0; in_ch.norm_gamma = '0; in_ch.norm_beta = '0;
    in_ch.last = 1'b0;
    acc_sum = '0; acc_ovf = 1'b0; mismatches = 0; results_seen = 0; beats_sent = 0;
    foreach (loaded[i]) begin
      loaded[i] = 1'b0;
      bn_mean[i] = '0; bn_root[i] = '0; bn_gamma[i] = '0; bn_beta[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(1200);
    in_ch.valid <= 1'b0;

    // drain, then allow for the window-end latency
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d beats (loads and windows over 64 filters), checked %0d results.",
             beats_sent, results_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[conv_window_bn_relu_unit] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("[conv_window_bn_relu_unit] ERROR");
    end
    $finish;
  end

endmodule
